// ----- sv/assert_macros.svh -----
// Assertion macros shared by the checked modules.
// No dependencies; included by the top level.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every clock edge outside reset.
`define SKR_ASSERT(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Check a property on every clock edge, reset included.
`define SKR_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// ----- sv/skrt_pkg.sv -----
// Types and constants for the site-keyed random table.
// No dependencies; used by every module of the block.
package skrt_pkg;

  localparam int ENTRIES   = 64;
  localparam int SLOT_W    = 6;
  localparam int ADDR_WORDS = 5;
  localparam logic [31:0] FULL_WORD = 32'hFFFF_FFFF;
  localparam logic [15:0] COUNT_LIMIT = 16'hFFFF;

  typedef struct packed {
    logic [31:0] addr_word_0;
    logic [31:0] addr_word_1;
    logic [31:0] addr_word_2;
    logic [31:0] addr_word_3;
    logic [31:0] addr_word_4;
    logic [7:0]  location_byte;
    logic [31:0] site_id;
    logic [31:0] random_word;
  } req_t;

  typedef struct packed {
    logic        hit;
    logic [5:0]  slot;
    logic [15:0] sample_row;
    logic [31:0] value;
    logic        rejected;
    logic        table_full;
  } rsp_t;

  // Lookup key: address words, location byte and site id.
  typedef struct packed {
    logic [ADDR_WORDS*32-1:0] addr;
    logic [39:0]              tag;
  } key_t;

  // Entry update broadcast to the cells.
  typedef struct packed {
    logic        alloc;
    logic [15:0] count;
    logic        phase;
    logic [31:0] mirror;
  } cell_wr_t;

  // Entry contents read back from one cell.
  typedef struct packed {
    logic [15:0] count;
    logic        phase;
    logic [31:0] mirror;
  } cell_rd_t;

  typedef enum logic {
    S_IDLE,
    S_WRITE
  } state_t;

  function automatic key_t make_key(req_t r);
    key_t k;
    k.addr = {r.addr_word_0, r.addr_word_1, r.addr_word_2, r.addr_word_3, r.addr_word_4};
    k.tag  = {r.location_byte, r.site_id};
    return k;
  endfunction

endpackage

// ----- sv/skrt_cell.sv -----
// One table entry: key, sample count, phase and mirror word.
// Depends on skrt_pkg. Hands its valid bit to the next cell in the row.
module skrt_cell (
  input  logic              clk,
  input  logic              rst,
  input  skrt_pkg::key_t    key,
  input  logic              capture,
  input  logic              prev_valid,
  input  logic              we,
  input  skrt_pkg::cell_wr_t wr,
  output logic              valid,
  output logic              head,
  output logic              matched,
  output skrt_pkg::cell_rd_t rd
);
  import skrt_pkg::*;

  key_t        stored_key;
  logic [15:0] count;
  logic        phase;
  logic [31:0] mirror;

  // First free cell of the row: the one before it is taken, this one is not.
  assign head = prev_valid & ~valid;
  assign rd   = '{count: count, phase: phase, mirror: mirror};

  always_ff @(posedge clk) begin
    if (rst) begin
      valid   <= 1'b0;
      matched <= 1'b0;
    end else begin
      if (capture) begin
        matched <= valid && (stored_key == key);
      end
      if (we && wr.alloc) begin
        valid <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (we) begin
      if (wr.alloc) begin
        stored_key <= key;
      end
      count  <= wr.count;
      phase  <= wr.phase;
      mirror <= wr.mirror;
    end
  end

endmodule

// ----- sv/site_keyed_random_table.sv -----
// Site-keyed random table, top level.
// Request channel in_valid/in_stall/in_data: one request carries a lookup key
// (five address words, location byte, site id) and a fresh random word.
// Result channel out_valid/out_stall/out_data: one result per request.
// Config channel cfg_valid/cfg_ready/cfg_data writes antithetic_mode; write
// it only while no request is in flight.
// Each request has a capture step and a resolve step: the transfer edge
// captures the key and every cell compares it in parallel against its
// entry; the resolve edge, once the output register is free, resolves the
// hit or allocation, updates the chosen cell and loads the output register.
// The lookup sequencer holds one request at a time, taking no new request
// until the held one has resolved. Output valid rises on the resolve edge.
// When the receiver stalls, the held result waits in the output register and
// the next request waits in the resolve cycle until that register frees.
// Reset empties the table (all cells invalid), sets antithetic mode and
// drops any held result. Allocation fills the cells in order, first free
// cell first; a full table answers misses with table_full.
module site_keyed_random_table (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_stall,
  input  skrt_pkg::req_t in_data,
  output logic           out_valid,
  input  logic           out_stall,
  output skrt_pkg::rsp_t out_data,
  input  logic           cfg_valid,
  output logic           cfg_ready,
  input  logic           cfg_data
);
  import skrt_pkg::*;

  `include "assert_macros.svh"

  state_t      state, state_next;
  logic        antithetic_mode;
  req_t        req;
  key_t        cell_key;
  logic        capture;
  logic        resolve;
  logic        cell_we [ENTRIES];
  cell_wr_t    wr;
  logic [ENTRIES-1:0] valid_vec, head_vec, match_vec, sel_vec;
  cell_rd_t    rd_vec [ENTRIES];
  cell_rd_t    rd_sel;
  logic [SLOT_W-1:0] slot_sel;
  logic        hit, full_miss;
  rsp_t        rsp;

  assign cfg_ready = 1'b1;
  assign in_stall  = (state != S_IDLE);
  assign capture   = in_valid && !in_stall;
  // In idle the live payload is compared; on the resolve cycle the held key is written.
  assign cell_key  = (state == S_IDLE) ? make_key(in_data) : make_key(req);
  assign resolve   = (state == S_WRITE) && (!out_valid || !out_stall);

  genvar g;
  generate
    for (g = 0; g < ENTRIES; g++) begin : g_cell
      logic prev_valid;
      if (g == 0) begin : g_first
        assign prev_valid = 1'b1;
      end else begin : g_rest
        assign prev_valid = valid_vec[g-1];
      end
      assign cell_we[g] = resolve && !full_miss && sel_vec[g];
      skrt_cell u_cell (
        .clk       (clk),
        .rst       (rst),
        .key       (cell_key),
        .capture   (capture),
        .prev_valid(prev_valid),
        .we        (cell_we[g]),
        .wr        (wr),
        .valid     (valid_vec[g]),
        .head      (head_vec[g]),
        .matched   (match_vec[g]),
        .rd        (rd_vec[g])
      );
    end
  endgenerate

  assign hit       = |match_vec;
  assign full_miss = !hit && valid_vec[ENTRIES-1];
  assign sel_vec   = hit ? match_vec : head_vec;

  // Gather the selected entry and its slot number.
  always_comb begin
    rd_sel   = '0;
    slot_sel = '0;
    for (int i = 0; i < ENTRIES; i++) begin
      if (sel_vec[i]) begin
        rd_sel   = rd_sel | rd_vec[i];
        slot_sel = slot_sel | SLOT_W'(i);
      end
    end
  end

  always_comb begin
    cell_rd_t cur;
    cur = hit ? rd_sel : cell_rd_t'('0);
    wr  = '{alloc: !hit, count: cur.count, phase: cur.phase, mirror: cur.mirror};
    rsp = '0;
    if (full_miss) begin
      rsp.table_full = 1'b1;
    end else begin
      rsp.hit  = hit;
      rsp.slot = slot_sel;
      if (antithetic_mode) begin
        if (!cur.phase) begin
          if (req.random_word == '0 || req.random_word == FULL_WORD) begin
            rsp.rejected = 1'b1;
          end else begin
            rsp.value = req.random_word;
            wr.mirror = FULL_WORD - req.random_word;
            wr.phase  = 1'b1;
          end
        end else begin
          rsp.value = cur.mirror;
          wr.phase  = 1'b0;
        end
      end else begin
        rsp.sample_row = cur.count;
        if (cur.count < COUNT_LIMIT) begin
          wr.count = cur.count + 16'd1;
        end
      end
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE:  if (capture) state_next = S_WRITE;
      S_WRITE: if (resolve) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= S_IDLE;
      antithetic_mode <= 1'b1;
      out_valid       <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_valid && cfg_ready) begin
        antithetic_mode <= cfg_data;
      end
      if (resolve) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (capture) begin
      req <= in_data;
    end
    if (resolve) begin
      out_data <= rsp;
    end
  end

  `SKR_ASSERT(a_match_unique, clk, rst, $onehot0(match_vec), "key matched two entries")
  `SKR_ASSERT(a_head_unique, clk, rst, $onehot0(head_vec), "more than one free head cell")
  `SKR_ASSERT(a_hit_not_full, clk, rst, out_valid |-> !(out_data.hit && out_data.table_full),
              "hit and table_full together")
  `SKR_ASSERT(a_fill_order, clk, rst, resolve && !full_miss && !hit |=> $countones(valid_vec)
              == $countones($past(valid_vec)) + 1, "allocation did not take one cell")

endmodule
